[src/e8alu_pkg.sv]
// Shared types, operation codes and helper functions for the 8-bit ALU.
package e8alu_pkg;

  typedef logic [7:0] byte_t;

  typedef enum logic [5:0] {
    OP_ORA = 6'd0,  OP_AND = 6'd1,  OP_EOR = 6'd2,  OP_ADC = 6'd3,
    OP_SBC = 6'd4,  OP_CMP = 6'd5,  OP_CPX = 6'd6,  OP_CPY = 6'd7,
    OP_LDA = 6'd8,  OP_LDX = 6'd9,  OP_LDY = 6'd10, OP_BIT = 6'd11,
    OP_ASL = 6'd12, OP_LSR = 6'd13, OP_ROL = 6'd14, OP_ROR = 6'd15,
    OP_INC = 6'd16, OP_DEC = 6'd17, OP_INX = 6'd18, OP_DEX = 6'd19,
    OP_INY = 6'd20, OP_DEY = 6'd21, OP_SLO = 6'd22, OP_RLA = 6'd23,
    OP_SRE = 6'd24, OP_RRA = 6'd25, OP_DCP = 6'd26, OP_ISC = 6'd27,
    OP_TAX = 6'd28, OP_TAY = 6'd29, OP_TXA = 6'd30, OP_TYA = 6'd31,
    OP_CLC = 6'd32, OP_SEC = 6'd33, OP_CLV = 6'd34, OP_CLD = 6'd35,
    OP_SED = 6'd36, OP_CLI = 6'd37, OP_SEI = 6'd38, OP_LAX = 6'd39
  } kind_t;

  typedef enum logic [2:0] {
    TGT_A,
    TGT_X,
    TGT_Y,
    TGT_P,
    TGT_MEM
  } tgt_t;

  localparam int FLAG_C = 0;
  localparam int FLAG_Z = 1;
  localparam int FLAG_I = 2;
  localparam int FLAG_D = 3;
  localparam int FLAG_V = 6;
  localparam int FLAG_N = 7;

  typedef struct packed {
    logic  c;
    logic  v;
    byte_t r;
  } adc_res_t;

  typedef struct packed {
    logic c;
    logic z;
    logic n;
  } cmp_res_t;

  function automatic adc_res_t adc8(input byte_t a, input byte_t m, input logic cin);
    logic [8:0] sum;
    adc_res_t   o;
    sum = {1'b0, a} + {1'b0, m} + {8'd0, cin};
    o.c = sum[8];
    o.v = ~(a[7] ^ m[7]) & (a[7] ^ sum[7]);
    o.r = sum[7:0];
    return o;
  endfunction

  function automatic cmp_res_t cmp8(input byte_t r, input byte_t m);
    logic [8:0] diff;
    cmp_res_t   o;
    diff = {1'b0, r} - {1'b0, m};
    o.c = ~diff[8];
    o.z = (r == m);
    o.n = diff[7];
    return o;
  endfunction

endpackage

[src/e8alu_ifs.sv]
// Valid/ready channel interfaces for ALU items and results.
interface e8alu_in_if;
  import e8alu_pkg::*;
  logic  valid;
  logic  ready;
  kind_t kind;
  byte_t operand;
  modport source(output valid, output kind, output operand, input ready);
  modport sink(input valid, input kind, input operand, output ready);
endinterface

interface e8alu_out_if;
  import e8alu_pkg::*;
  logic  valid;
  logic  ready;
  byte_t result_value;
  logic  write_back;
  byte_t acc;
  byte_t index_x;
  byte_t index_y;
  byte_t status_flags;
  modport source(output valid, output result_value, output write_back, output acc,
                 output index_x, output index_y, output status_flags, input ready);
  modport sink(input valid, input result_value, input write_back, input acc,
               input index_x, input index_y, input status_flags, output ready);
endinterface

[src/eight_bit_cpu_alu_with_flags.sv]
// 8-bit ALU with accumulator, X, Y and status registers.
// An item is held in the input register, then its result in the result register;
// one item per cycle is sustained while the output is not stalled.
// Flags and registers written by one item feed the next item.
// Reset (rst_n low, synchronous) clears A, X, Y, status and both stage valids.
module eight_bit_cpu_alu_with_flags (
  input logic         clk,
  input logic         rst_n,
  e8alu_in_if.sink    in_ch,
  e8alu_out_if.source out_ch
);
  import e8alu_pkg::*;

  logic  s1_valid_r;
  kind_t kind_r;
  byte_t operand_r;

  byte_t acc_r, acc_nxt;
  byte_t x_r, x_nxt;
  byte_t y_r, y_nxt;
  byte_t flags_r, flags_nxt;

  logic  out_valid_r;
  byte_t res_r, res_nxt;
  logic  wb_r, wb_nxt;

  logic  advance;
  logic  fire;

  assign advance = ~out_valid_r | out_ch.ready;
  assign fire    = s1_valid_r & advance;
  assign in_ch.ready = ~s1_valid_r | advance;

  // hold the item until the result stage takes it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
    if (in_ch.valid && in_ch.ready) begin
      kind_r    <= in_ch.kind;
      operand_r <= in_ch.operand;
    end
  end

  always_comb begin
    byte_t    m;
    byte_t    shl;
    byte_t    rol;
    byte_t    lsr;
    byte_t    ror;
    byte_t    inc;
    byte_t    dec;
    byte_t    nz_val;
    logic     nz_en;
    tgt_t     tgt;
    adc_res_t ad;
    cmp_res_t cp;

    m   = operand_r;
    shl = {m[6:0], 1'b0};
    rol = {m[6:0], flags_r[FLAG_C]};
    lsr = {1'b0, m[7:1]};
    ror = {flags_r[FLAG_C], m[7:1]};
    inc = m + 8'd1;
    dec = m - 8'd1;

    acc_nxt   = acc_r;
    x_nxt     = x_r;
    y_nxt     = y_r;
    flags_nxt = flags_r;
    res_nxt   = 8'd0;
    nz_val    = 8'd0;
    nz_en     = 1'b0;
    tgt       = TGT_A;
    ad        = adc8(acc_r, m, flags_r[FLAG_C]);
    cp        = cmp8(acc_r, m);

    case (kind_r)
      OP_ORA: begin acc_nxt = acc_r | m; nz_val = acc_nxt; nz_en = 1'b1; end
      OP_AND: begin acc_nxt = acc_r & m; nz_val = acc_nxt; nz_en = 1'b1; end
      OP_EOR: begin acc_nxt = acc_r ^ m; nz_val = acc_nxt; nz_en = 1'b1; end
      OP_ADC, OP_SBC: begin
        if (kind_r == OP_SBC) ad = adc8(acc_r, ~m, flags_r[FLAG_C]);
        acc_nxt = ad.r;
        flags_nxt[FLAG_C] = ad.c;
        flags_nxt[FLAG_V] = ad.v;
        nz_val = ad.r; nz_en = 1'b1;
      end
      OP_CMP, OP_CPX, OP_CPY: begin
        if (kind_r == OP_CPX) begin
          cp = cmp8(x_r, m); tgt = TGT_X;
        end else if (kind_r == OP_CPY) begin
          cp = cmp8(y_r, m); tgt = TGT_Y;
        end
        flags_nxt[FLAG_C] = cp.c;
        flags_nxt[FLAG_Z] = cp.z;
        flags_nxt[FLAG_N] = cp.n;
      end
      OP_LDA: begin acc_nxt = m; nz_val = m; nz_en = 1'b1; end
      OP_LDX: begin x_nxt = m; nz_val = m; nz_en = 1'b1; tgt = TGT_X; end
      OP_LDY: begin y_nxt = m; nz_val = m; nz_en = 1'b1; tgt = TGT_Y; end
      OP_LAX: begin acc_nxt = m; x_nxt = m; nz_val = m; nz_en = 1'b1; end
      OP_BIT: begin
        flags_nxt[FLAG_N] = m[7];
        flags_nxt[FLAG_V] = m[6];
        flags_nxt[FLAG_Z] = ((acc_r & m) == 8'd0);
      end
      OP_ASL: begin
        res_nxt = shl; flags_nxt[FLAG_C] = m[7]; nz_val = shl; nz_en = 1'b1; tgt = TGT_MEM;
      end
      OP_ROL: begin
        res_nxt = rol; flags_nxt[FLAG_C] = m[7]; nz_val = rol; nz_en = 1'b1; tgt = TGT_MEM;
      end
      OP_LSR: begin
        res_nxt = lsr; flags_nxt[FLAG_C] = m[0]; nz_val = lsr; nz_en = 1'b1; tgt = TGT_MEM;
      end
      OP_ROR: begin
        res_nxt = ror; flags_nxt[FLAG_C] = m[0]; nz_val = ror; nz_en = 1'b1; tgt = TGT_MEM;
      end
      OP_INC: begin res_nxt = inc; nz_val = inc; nz_en = 1'b1; tgt = TGT_MEM; end
      OP_DEC: begin res_nxt = dec; nz_val = dec; nz_en = 1'b1; tgt = TGT_MEM; end
      OP_INX: begin x_nxt = x_r + 8'd1; nz_val = x_nxt; nz_en = 1'b1; tgt = TGT_X; end
      OP_DEX: begin x_nxt = x_r - 8'd1; nz_val = x_nxt; nz_en = 1'b1; tgt = TGT_X; end
      OP_INY: begin y_nxt = y_r + 8'd1; nz_val = y_nxt; nz_en = 1'b1; tgt = TGT_Y; end
      OP_DEY: begin y_nxt = y_r - 8'd1; nz_val = y_nxt; nz_en = 1'b1; tgt = TGT_Y; end
      OP_SLO: begin
        res_nxt = shl; flags_nxt[FLAG_C] = m[7];
        acc_nxt = acc_r | shl; nz_val = acc_nxt; nz_en = 1'b1; tgt = TGT_MEM;
      end
      OP_RLA: begin
        res_nxt = rol; flags_nxt[FLAG_C] = m[7];
        acc_nxt = acc_r & rol; nz_val = acc_nxt; nz_en = 1'b1; tgt = TGT_MEM;
      end
      OP_SRE: begin
        res_nxt = lsr; flags_nxt[FLAG_C] = m[0];
        acc_nxt = acc_r ^ lsr; nz_val = acc_nxt; nz_en = 1'b1; tgt = TGT_MEM;
      end
      OP_RRA: begin
        res_nxt = ror;
        ad = adc8(acc_r, ror, m[0]);
        acc_nxt = ad.r;
        flags_nxt[FLAG_C] = ad.c;
        flags_nxt[FLAG_V] = ad.v;
        nz_val = ad.r; nz_en = 1'b1; tgt = TGT_MEM;
      end
      OP_DCP: begin
        res_nxt = dec;
        cp = cmp8(acc_r, dec);
        flags_nxt[FLAG_C] = cp.c;
        flags_nxt[FLAG_Z] = cp.z;
        flags_nxt[FLAG_N] = cp.n;
        tgt = TGT_MEM;
      end
      OP_ISC: begin
        res_nxt = inc;
        ad = adc8(acc_r, ~inc, flags_r[FLAG_C]);
        acc_nxt = ad.r;
        flags_nxt[FLAG_C] = ad.c;
        flags_nxt[FLAG_V] = ad.v;
        nz_val = ad.r; nz_en = 1'b1; tgt = TGT_MEM;
      end
      OP_TAX: begin x_nxt = acc_r; nz_val = acc_r; nz_en = 1'b1; tgt = TGT_X; end
      OP_TAY: begin y_nxt = acc_r; nz_val = acc_r; nz_en = 1'b1; tgt = TGT_Y; end
      OP_TXA: begin acc_nxt = x_r; nz_val = x_r; nz_en = 1'b1; end
      OP_TYA: begin acc_nxt = y_r; nz_val = y_r; nz_en = 1'b1; end
      OP_CLC: begin flags_nxt[FLAG_C] = 1'b0; tgt = TGT_P; end
      OP_SEC: begin flags_nxt[FLAG_C] = 1'b1; tgt = TGT_P; end
      OP_CLV: begin flags_nxt[FLAG_V] = 1'b0; tgt = TGT_P; end
      OP_CLD: begin flags_nxt[FLAG_D] = 1'b0; tgt = TGT_P; end
      OP_SED: begin flags_nxt[FLAG_D] = 1'b1; tgt = TGT_P; end
      OP_CLI: begin flags_nxt[FLAG_I] = 1'b0; tgt = TGT_P; end
      OP_SEI: begin flags_nxt[FLAG_I] = 1'b1; tgt = TGT_P; end
      default: begin
        tgt = TGT_A;
      end
    endcase

    if (nz_en) begin
      flags_nxt[FLAG_N] = nz_val[7];
      flags_nxt[FLAG_Z] = (nz_val == 8'd0);
    end

    wb_nxt = 1'b0;
    case (tgt)
      TGT_X:   res_nxt = x_nxt;
      TGT_Y:   res_nxt = y_nxt;
      TGT_P:   res_nxt = flags_nxt;
      TGT_MEM: wb_nxt  = 1'b1;
      default: res_nxt = acc_nxt;
    endcase
  end

  // advance registers and result together
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r       <= 8'd0;
      x_r         <= 8'd0;
      y_r         <= 8'd0;
      flags_r     <= 8'd0;
      out_valid_r <= 1'b0;
    end else begin
      if (advance) begin
        out_valid_r <= s1_valid_r;
      end
      if (fire) begin
        acc_r   <= acc_nxt;
        x_r     <= x_nxt;
        y_r     <= y_nxt;
        flags_r <= flags_nxt;
      end
    end
    if (fire) begin
      res_r <= res_nxt;
      wb_r  <= wb_nxt;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.result_value = res_r;
  assign out_ch.write_back   = wb_r;
  assign out_ch.acc          = acc_r;
  assign out_ch.index_x      = x_r;
  assign out_ch.index_y      = y_r;
  assign out_ch.status_flags = flags_r;

`ifndef SYNTHESIS
  a_unused_flags_zero: assert property (@(posedge clk) disable iff (!rst_n)
    flags_r[5:4] == 2'b00)
    else $error("status bits 4 and 5 changed");

  a_stage_drains: assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> out_valid_r)
    else $error("item lost between stages");

  a_state_held: assert property (@(posedge clk) disable iff (!rst_n)
    !fire |=> acc_r == $past(acc_r) && x_r == $past(x_r) && y_r == $past(y_r)
              && flags_r == $past(flags_r))
    else $error("register state changed without an item");

  a_stall_holds_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ch.ready |=> $stable(res_r) && $stable(wb_r))
    else $error("result changed while stalled");
`endif

endmodule
